@@ hw/rtl/rpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types, constants and helpers of the RTCP packet classifier.
// ----------------------------------------------------------------------------
package rpc_pkg;

  // Payload length and byte position width
  localparam int LENGTH_BITS = 16;
  // Width of the section end sum (section start plus a 16-bit section size)
  localparam int SUM_W       = 17;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERLEAVE_PORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UDP_MIN_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UDP_MAX_LENGTH  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] INTERLEAVE_PORT_RST = 16'd554;
  localparam logic [CFG_W-1:0] UDP_MIN_LENGTH_RST  = 16'd28;
  localparam logic [CFG_W-1:0] UDP_MAX_LENGTH_RST  = 16'd1200;

  // Transport codes
  localparam logic [1:0] TRANSPORT_TCP = 2'd0;
  localparam logic [1:0] TRANSPORT_UDP = 2'd1;

  // Verdict codes
  localparam logic VERDICT_RTCP     = 1'b0;
  localparam logic VERDICT_EXCLUDED = 1'b1;

  // Header byte values
  localparam logic [7:0] RTCP_V2_NO_PAD  = 8'h80;
  localparam logic [7:0] RTCP_V2_ONE_RC  = 8'h81;
  localparam logic [7:0] RTCP_PT_SR      = 8'hc8;
  localparam logic [7:0] RTCP_PT_RR      = 8'hc9;

  // Length thresholds
  localparam logic [LENGTH_BITS-1:0] TCP_PREFIX_LEN  = LENGTH_BITS'(8);
  localparam logic [LENGTH_BITS-1:0] TCP_LAST_PREFIX = LENGTH_BITS'(7);
  localparam logic [LENGTH_BITS-1:0] TCP_MIN_EXCL    = LENGTH_BITS'(13);
  localparam logic [LENGTH_BITS-1:0] UDP_ALT_MIN     = LENGTH_BITS'(3);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX         = '1;

  // Header flag bits
  localparam int HF_V80  = 0;
  localparam int HF_V81  = 1;
  localparam int HF_PT   = 2;
  localparam int HF_ZERO = 3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [1:0]  transport;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_length;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] interleave_port;
    logic [CFG_W-1:0] udp_min_length;
    logic [CFG_W-1:0] udp_max_length;
  } cfg_t;

  typedef struct packed {
    logic has_result;
    logic verdict;
  } eval_res_t;

  // Fixed byte pattern that opens an interleaved TCP RTCP stream
  function automatic logic [7:0] tcp_prefix_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h00;
      3'd1:    val = 8'h00;
      3'd2:    val = 8'h01;
      3'd3:    val = 8'h01;
      3'd4:    val = 8'h08;
      3'd5:    val = 8'h0a;
      3'd6:    val = 8'h00;
      default: val = 8'h01;
    endcase
    return val;
  endfunction

endpackage

@@ hw/rtl/rpc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_if
// Valid/ready channels of the classifier: payload byte requests in, verdicts out.
// ----------------------------------------------------------------------------
interface rpc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [1:0]  transport;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] payload_length;
  logic        last_byte;

  modport source (output valid, data_byte, transport, source_port, dest_port,
                  payload_length, last_byte, input ready);
  modport sink   (input valid, data_byte, transport, source_port, dest_port,
                  payload_length, last_byte, output ready);
endinterface

interface rpc_out_if;
  logic valid;
  logic ready;
  logic verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

@@ hw/rtl/rtcp_packet_classifier_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcp_packet_classifier_core
// Streaming RTCP detector: one payload byte per request, one verdict per
// packet where a verdict applies.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one payload byte per request with the packet's transport,
//   ports and payload length; last_byte closes the packet. out_chan carries
//   the verdict (0 RTCP, 1 excluded); packets with no verdict give nothing.
//   cfg_wr_en/cfg_index/cfg_wdata write the interleave port and the UDP
//   length bounds; write them only while no packet is in flight.
// Timing:
//   One request per cycle is accepted when the receiver keeps up. A byte is
//   held in the input register, evaluated combinationally against the packet
//   state, and its verdict lands in the result register: the closing byte
//   passes the input register, then the result register shows its verdict.
// Reset and stall:
//   rst_n (synchronous, active low) clears both stages, the packet state and
//   loads the register defaults. When out_chan stalls, the verdict holds in
//   the result register and the input stage keeps one more request before
//   in_chan.ready drops.
// ----------------------------------------------------------------------------
module rtcp_packet_classifier_core
  import rpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  rpc_in_if.sink               in_chan,
  rpc_out_if.source            out_chan,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t      cfg;
  in_item_t  item;
  logic      item_valid;
  logic      can_load;
  logic      advance;
  eval_res_t res;

  // Move the held byte forward whenever the result register can take it
  assign advance = item_valid && can_load;

  rpc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rpc_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .can_advance (can_load),
    .item_valid  (item_valid),
    .item        (item)
  );

  rpc_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .res     (res)
  );

  rpc_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .can_load (can_load),
    .out_chan (out_chan)
  );

endmodule

@@ hw/rtl/rpc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_cfg_regs
// Configuration register file: interleave port and UDP length bounds.
// ----------------------------------------------------------------------------
module rpc_cfg_regs
  import rpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interleave_port <= INTERLEAVE_PORT_RST;
      cfg_r.udp_min_length  <= UDP_MIN_LENGTH_RST;
      cfg_r.udp_max_length  <= UDP_MAX_LENGTH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_INTERLEAVE_PORT: cfg_r.interleave_port <= cfg_wdata;
        REG_UDP_MIN_LENGTH:  cfg_r.udp_min_length  <= cfg_wdata;
        REG_UDP_MAX_LENGTH:  cfg_r.udp_max_length  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/rpc_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_in_reg
// Input register stage: captures one byte request per cycle unless the result side stalls.
// ----------------------------------------------------------------------------
module rpc_in_reg
  import rpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  rpc_in_if.sink   in_chan,
  input  logic     can_advance,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r;
  in_item_t item_r;
  logic     take;

  // Accept when empty or when the held request moves on this cycle
  assign in_chan.ready = !valid_r || can_advance;
  assign take          = in_chan.valid && in_chan.ready;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.data_byte      <= in_chan.data_byte;
      item_r.transport      <= in_chan.transport;
      item_r.source_port    <= in_chan.source_port;
      item_r.dest_port      <= in_chan.dest_port;
      item_r.payload_length <= in_chan.payload_length;
      item_r.last_byte      <= in_chan.last_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ hw/rtl/rpc_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_eval
// Per-packet state and verdict logic: TCP prefix check, header flags and
// the walk over the compound section length words.
// ----------------------------------------------------------------------------
module rpc_eval
  import rpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output eval_res_t res
);

  logic [LENGTH_BITS-1:0] byte_pos_r,    byte_pos_nxt;
  logic [LENGTH_BITS-1:0] sect_start_r,  sect_start_nxt;
  logic [7:0]             len_high_r,    len_high_nxt;
  logic                   walk_failed_r, walk_failed_nxt;
  logic [3:0]             hdr_flags_r,   hdr_flags_nxt;
  logic                   prefix_ok_r,   prefix_ok_nxt;

  logic [LENGTH_BITS-1:0] plen;
  logic [LENGTH_BITS-1:0] p;
  logic [7:0]             b;
  logic [LENGTH_BITS:0]   p_ext;
  logic [LENGTH_BITS:0]   start_plus2;
  logic [LENGTH_BITS:0]   start_plus3;
  logic [15:0]            word;
  logic [15:0]            sec;
  logic [SUM_W-1:0]       sect_end;
  logic [CFG_W-1:0]       plen_cfg;
  logic                   port_hit;
  logic                   body_ok;
  logic                   verdict_valid;
  logic                   verdict;

  assign plen     = item.payload_length[LENGTH_BITS-1:0];
  assign p        = byte_pos_r;
  assign b        = item.data_byte;
  assign p_ext    = {1'b0, p};
  assign plen_cfg = CFG_W'(plen);

  // Section size is (word + 1) * 4, kept to 16 bits
  assign word        = {len_high_r, b};
  assign sec         = {word[13:0] + 14'd1, 2'b00};
  assign start_plus2 = {1'b0, sect_start_r} + (LENGTH_BITS+1)'(2);
  assign start_plus3 = {1'b0, sect_start_r} + (LENGTH_BITS+1)'(3);
  assign sect_end    = SUM_W'(sect_start_r) + SUM_W'(sec);

  // Next packet state for the current byte
  always_comb begin
    prefix_ok_nxt   = prefix_ok_r;
    hdr_flags_nxt   = hdr_flags_r;
    len_high_nxt    = len_high_r;
    sect_start_nxt  = sect_start_r;
    walk_failed_nxt = walk_failed_r;

    if (p < TCP_PREFIX_LEN && b != tcp_prefix_byte(p[2:0])) begin
      prefix_ok_nxt = 1'b0;
    end

    if (p == '0) begin
      if (b == RTCP_V2_NO_PAD) hdr_flags_nxt[HF_V80] = 1'b1;
      if (b == RTCP_V2_ONE_RC) hdr_flags_nxt[HF_V81] = 1'b1;
    end else if (p == LENGTH_BITS'(1)) begin
      if (b == RTCP_PT_SR || b == RTCP_PT_RR) hdr_flags_nxt[HF_PT] = 1'b1;
    end else if (p == LENGTH_BITS'(2)) begin
      if (b == 8'h00) hdr_flags_nxt[HF_ZERO] = 1'b1;
    end

    // Walk the section length words inside the declared payload
    if (!walk_failed_r && p < plen) begin
      if (p_ext == start_plus2) begin
        len_high_nxt = b;
      end else if (p_ext == start_plus3) begin
        if (sec == '0 || sect_end > SUM_W'(plen)) begin
          walk_failed_nxt = 1'b1;
        end else begin
          sect_start_nxt = sect_end[LENGTH_BITS-1:0];
        end
      end
    end

    // Advance the position, saturating at the top
    byte_pos_nxt = (p != LEN_MAX) ? p + LENGTH_BITS'(1) : p;
  end

  // Verdict on the closing byte, from the updated state
  assign port_hit = (item.source_port == cfg.interleave_port) ||
                    (item.dest_port == cfg.interleave_port);
  assign body_ok  = hdr_flags_nxt[HF_PT] && hdr_flags_nxt[HF_ZERO];

  always_comb begin
    verdict_valid = 1'b0;
    verdict       = VERDICT_EXCLUDED;
    case (item.transport)
      TRANSPORT_TCP: begin
        if (plen > TCP_MIN_EXCL && port_hit && prefix_ok_nxt && p >= TCP_LAST_PREFIX) begin
          verdict_valid = 1'b1;
          verdict       = VERDICT_RTCP;
        end
      end
      TRANSPORT_UDP: begin
        if (walk_failed_nxt) begin
          verdict_valid = 1'b1;
          verdict       = VERDICT_EXCLUDED;
        end else if (body_ok && hdr_flags_nxt[HF_V80] &&
                     plen_cfg >= cfg.udp_min_length && plen_cfg <= cfg.udp_max_length) begin
          verdict_valid = 1'b1;
          verdict       = VERDICT_RTCP;
        end else if (body_ok && hdr_flags_nxt[HF_V81] && plen >= UDP_ALT_MIN) begin
          verdict_valid = 1'b1;
          verdict       = VERDICT_RTCP;
        end
      end
      default: begin
        verdict_valid = 1'b1;
        verdict       = VERDICT_EXCLUDED;
      end
    endcase
  end

  assign res.has_result = advance && item.last_byte && verdict_valid;
  assign res.verdict    = verdict;

  // Update the packet state; clear it after the closing byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r    <= '0;
      sect_start_r  <= '0;
      len_high_r    <= '0;
      walk_failed_r <= 1'b0;
      hdr_flags_r   <= '0;
      prefix_ok_r   <= 1'b1;
    end else if (advance) begin
      if (item.last_byte) begin
        byte_pos_r    <= '0;
        sect_start_r  <= '0;
        len_high_r    <= '0;
        walk_failed_r <= 1'b0;
        hdr_flags_r   <= '0;
        prefix_ok_r   <= 1'b1;
      end else begin
        byte_pos_r    <= byte_pos_nxt;
        sect_start_r  <= sect_start_nxt;
        len_high_r    <= len_high_nxt;
        walk_failed_r <= walk_failed_nxt;
        hdr_flags_r   <= hdr_flags_nxt;
        prefix_ok_r   <= prefix_ok_nxt;
      end
    end
  end

endmodule

@@ hw/rtl/rpc_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_out_reg
// Result register: holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module rpc_out_reg
  import rpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  eval_res_t  res,
  output logic       can_load,
  rpc_out_if.source  out_chan
);

  logic valid_r;
  logic verdict_r;

  // Load when empty or when the held verdict is taken this cycle
  assign can_load = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= res.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && res.has_result) begin
      verdict_r <= res.verdict;
    end
  end

  assign out_chan.valid   = valid_r;
  assign out_chan.verdict = verdict_r;

endmodule

@@ hw/rtl/rpc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module rpc_checker
  import rpc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_verdict
);

  // Hold a stalled verdict request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict request dropped while stalled");

  // Keep a stalled verdict stable
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_verdict))
    else $error("verdict changed while stalled");

  // Drop input ready only when the result side is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input ready low without a stalled verdict");

  // Clear the result register at reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict shown right after reset");

endmodule

bind rtcp_packet_classifier_core rpc_checker u_rpc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_verdict (out_chan.verdict)
);
